>>> design/spmv_pkg.sv
// Shared types and constants for the sparse matrix-vector multiply block.
`timescale 1ns / 1ps
`default_nettype none

package spmv_pkg;

   // Field and datapath widths
   localparam int DATA_W   = 32;
   localparam int ACC_W    = 64;
   localparam int FRAC_W   = 16;
   localparam int ROW_W    = 20;
   localparam int CNT_W    = 21;
   localparam int INDEX_W  = 10;
   localparam int ACTION_W = 2;

   // Request action codes (code 3 is a no-op)
   localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_NONZERO = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_EMPTY   = 2'd2;

   // Largest row count honored; bigger values clamp to it
   localparam logic [CNT_W-1:0] ROW_LIMIT = 21'h10_0000;

   // Q16.16 saturation limits
   localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // Per-item control carried down the multiply-accumulate pipe
   typedef struct packed {
      logic emit;   // close the row after this item
      logic use_x;  // multiply by the stored vector entry
   } item_ctrl_type;

endpackage

`default_nettype wire

>>> design/spmv_vec_mem.sv
// Dense vector store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module spmv_vec_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  spmv_pkg::data_type       wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output spmv_pkg::data_type       rd_data
);
   import spmv_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   // Write loads; capture the read word only when the front stage moves
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/spmv_mac.sv
// Multiply-accumulate pipe: operand stage, product stage, row sum stage.
`timescale 1ns / 1ps
`default_nettype none

module spmv_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_en,
   input  spmv_pkg::item_ctrl_type  item_ctrl,
   input  spmv_pkg::data_type       item_data,
   input  spmv_pkg::data_type       vec_data,
   input  logic                     out_go,
   output logic                     front_go,
   output logic                     sum_valid,
   output spmv_pkg::acc_type        sum_data
);
   import spmv_pkg::*;

   logic          a_vld_ff;
   item_ctrl_type a_ctrl_ff;
   data_type      a_data_ff;

   logic          b_vld_ff;
   item_ctrl_type b_ctrl_ff;
   acc_type       b_prod_ff;
   acc_type       b_prod_in;

   logic          c_vld_ff;
   acc_type       c_fin_ff;
   acc_type       acc_ff;

   logic              go_a;
   logic              go_b;
   logic              go_c;
   logic signed [ACC_W:0] sum_wide;
   acc_type           sum_sat;

   // Each stage moves when the one below is empty or moving
   assign go_c     = !c_vld_ff || out_go;
   assign go_b     = !b_vld_ff || go_c;
   assign go_a     = !a_vld_ff || go_b;
   assign front_go = go_a;

   // Product of element and vector entry; zero when no entry is used
   always_comb begin
      b_prod_in = '0;
      if (a_ctrl_ff.use_x) begin
         b_prod_in = acc_type'(a_data_ff) * acc_type'(vec_data);
      end
   end

   // Saturating add of the product into the row sum
   always_comb begin
      sum_wide = {acc_ff[ACC_W-1], acc_ff} + {b_prod_ff[ACC_W-1], b_prod_ff};
      sum_sat  = sum_wide[ACC_W-1:0];
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   // Valid bits and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         if (go_a) begin
            a_vld_ff <= item_en;
         end
         if (go_b) begin
            b_vld_ff <= a_vld_ff;
         end
         if (go_c) begin
            c_vld_ff <= b_vld_ff && b_ctrl_ff.emit;
            if (b_vld_ff) begin
               acc_ff <= b_ctrl_ff.emit ? '0 : sum_sat;
            end
         end
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      if (go_a) begin
         a_ctrl_ff <= item_ctrl;
         a_data_ff <= item_data;
      end
      if (go_b) begin
         b_ctrl_ff <= a_ctrl_ff;
         b_prod_ff <= b_prod_in;
      end
      if (go_c) begin
         c_fin_ff <= sum_sat;
      end
   end

   assign sum_valid = c_vld_ff;
   assign sum_data  = c_fin_ff;

`ifndef SYNTHESIS
   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      go_c && b_vld_ff && b_ctrl_ff.emit |=> acc_ff == '0)
      else $error("row sum not cleared after row end");

   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      c_vld_ff && !out_go |=> c_vld_ff && $stable(c_fin_ff))
      else $error("finished row sum lost while output stalled");

   a_prod_zero: assert property (@(posedge clock) disable iff (reset)
      go_b && a_vld_ff && !a_ctrl_ff.use_x |=> b_prod_ff == '0)
      else $error("product nonzero for item without vector entry");
`endif

endmodule

`default_nettype wire

>>> design/spmv_emit.sv
// Row result stage: rounding to Q16.16, saturation, row counter, output register.
`timescale 1ns / 1ps
`default_nettype none

module spmv_emit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [spmv_pkg::CNT_W-1:0]      csr_wr_data,
   input  logic                            sum_valid,
   input  spmv_pkg::acc_type               sum_data,
   output logic                            out_go,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [spmv_pkg::ROW_W-1:0]      rsp_row_number,
   output spmv_pkg::data_type              rsp_row_result,
   output logic                            rsp_final_row,
   output logic                            rsp_clipped
);
   import spmv_pkg::*;

   localparam int Q_W = ACC_W - FRAC_W + 1;
   localparam logic signed [ACC_W:0] HALF_LSB =
      {{(ACC_W - FRAC_W + 1){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

   logic [CNT_W-1:0] row_count_ff;
   logic [ROW_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   data_type         rsp_result_ff;
   logic             rsp_final_ff;
   logic             rsp_clip_ff;

   logic                  load_o;
   logic signed [ACC_W:0] rnd_sum;
   logic signed [Q_W-1:0] q_full;
   logic [Q_W-DATA_W:0]   q_hi;
   data_type              result_in;
   logic                  clip_in;
   logic [CNT_W-1:0]      eff_count;
   logic [CNT_W-1:0]      cnt_inc;
   logic                  last_in;

   assign out_go = !rsp_valid_ff || rsp_ready;
   assign load_o = out_go && sum_valid;

   // Round to nearest, ties up, then clamp to 32 bits
   always_comb begin
      rnd_sum   = {sum_data[ACC_W-1], sum_data} + HALF_LSB;
      q_full    = rnd_sum[ACC_W:FRAC_W];
      q_hi      = q_full[Q_W-1:DATA_W-1];
      clip_in   = !((&q_hi) || !(|q_hi));
      result_in = q_full[DATA_W-1:0];
      if (clip_in) begin
         result_in = q_full[Q_W-1] ? DATA_MIN : DATA_MAX;
      end
   end

   // Clamp the row count and detect the last row
   always_comb begin
      eff_count = row_count_ff;
      if (row_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (row_count_ff > ROW_LIMIT) begin
         eff_count = ROW_LIMIT;
      end
      cnt_inc = {1'b0, cnt_ff} + CNT_W'(1);
      last_in = cnt_inc >= eff_count;
   end

   // Control: row count register, row counter, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CNT_W'(1);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            row_count_ff <= csr_wr_data;
         end
         if (out_go) begin
            rsp_valid_ff <= sum_valid;
         end
         if (load_o) begin
            cnt_ff <= last_in ? '0 : cnt_inc[ROW_W-1:0];
         end
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (load_o) begin
         rsp_row_ff    <= cnt_ff;
         rsp_result_ff <= result_in;
         rsp_final_ff  <= last_in;
         rsp_clip_ff   <= clip_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_number = rsp_row_ff;
   assign rsp_row_result = rsp_result_ff;
   assign rsp_final_row  = rsp_final_ff;
   assign rsp_clipped    = rsp_clip_ff;

`ifndef SYNTHESIS
   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clip_ff |-> rsp_result_ff == DATA_MAX || rsp_result_ff == DATA_MIN)
      else $error("clipped result not at a saturation limit");

   a_wrap: assert property (@(posedge clock) disable iff (reset)
      load_o && last_in |=> cnt_ff == '0)
      else $error("row counter did not wrap after final row");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      load_o && !last_in |=> cnt_ff == $past(cnt_inc[ROW_W-1:0]))
      else $error("row counter did not advance by one");
`endif

endmodule

`default_nettype wire

>>> design/sparse_csr_matrix_vector_multiply.sv
// Top level of the streaming CSR sparse matrix times dense vector unit.
//
// Usage: the req_ channel carries one beat per item. A load beat (action 0)
// writes req_data into vector entry req_index. A nonzero beat (action 1)
// multiplies req_data by the vector entry at column req_index and adds the
// Q32.32 product to the row sum; with req_ends_row set it closes the row.
// An empty-row beat (action 2) closes the row with the current sum.
// Closing a row sends one rsp_ beat: row number, Q16.16 result rounded to
// nearest and saturated (rsp_clipped), and rsp_final_row on the last row.
// The row counter wraps after csr_wr_data rows (written while idle).
// Throughput: one beat per cycle on req_ while req_ready is high, no matter
// the action mix. The vector store read is registered with the beat, then
// the multiply, the accumulate and the rounding each end in a register, so
// a result reaches rsp_ through the product, row sum and output registers.
// Reset clears the row sum, row counter and pipe, and sets the row count to
// one; vector entries stay unknown until loaded. When rsp_ready is low the
// pipe keeps filling its empty stages and takes beats until every stage
// holds work; then req_ready falls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module sparse_csr_matrix_vector_multiply #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [spmv_pkg::ACTION_W-1:0]     req_action,
   input  logic [spmv_pkg::INDEX_W-1:0]      req_index,
   input  logic signed [spmv_pkg::DATA_W-1:0] req_data,
   input  logic                              req_ends_row,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spmv_pkg::ROW_W-1:0]        rsp_row_number,
   output logic signed [spmv_pkg::DATA_W-1:0] rsp_row_result,
   output logic                              rsp_final_row,
   output logic                              rsp_clipped,
   input  logic                              csr_wr_en,
   input  logic [spmv_pkg::CNT_W-1:0]        csr_wr_data
);
   import spmv_pkg::*;

   localparam int ADDR_W = $clog2(VECTOR_DEPTH);

   logic          accept;
   logic          is_load;
   logic          is_nonzero;
   logic          is_empty;
   logic [31:0]   idx_wide;
   logic          in_range;
   logic [ADDR_W-1:0] addr;
   item_ctrl_type item_ctrl;
   logic          item_en;
   logic          front_go;
   logic          out_go;
   logic          sum_valid;
   acc_type       sum_data;
   data_type      vec_data;

   // Decode the request beat
   assign accept     = req_valid && req_ready;
   assign is_load    = req_action == ACT_LOAD;
   assign is_nonzero = req_action == ACT_NONZERO;
   assign is_empty   = req_action == ACT_EMPTY;
   assign idx_wide   = 32'(req_index);
   assign in_range   = idx_wide < 32'(VECTOR_DEPTH);
   assign addr       = idx_wide[ADDR_W-1:0];

   assign item_en         = accept && (is_nonzero || is_empty);
   assign item_ctrl.emit  = is_empty || (is_nonzero && req_ends_row);
   assign item_ctrl.use_x = is_nonzero && in_range;
   assign req_ready       = front_go;

   spmv_vec_mem #(
      .DEPTH  (VECTOR_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_vec_mem (
      .clock   (clock),
      .wr_en   (accept && is_load && in_range),
      .wr_addr (addr),
      .wr_data (req_data),
      .rd_en   (front_go),
      .rd_addr (addr),
      .rd_data (vec_data)
   );

   spmv_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .item_en   (item_en),
      .item_ctrl (item_ctrl),
      .item_data (req_data),
      .vec_data  (vec_data),
      .out_go    (out_go),
      .front_go  (front_go),
      .sum_valid (sum_valid),
      .sum_data  (sum_data)
   );

   spmv_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .sum_valid      (sum_valid),
      .sum_data       (sum_data),
      .out_go         (out_go),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_number (rsp_row_number),
      .rsp_row_result (rsp_row_result),
      .rsp_final_row  (rsp_final_row),
      .rsp_clipped    (rsp_clipped)
   );

endmodule

`default_nettype wire
